### rtl/qru_pkg.sv
package qru_pkg;

	localparam int FRAC_BITS  = 14;
	localparam int QUAT_WIDTH = 16;
	localparam int VEC_WIDTH  = 24;
	localparam int OUT_WIDTH  = 24;

	// Matrix entries saturate to the quaternion width when it is the narrower one.
	localparam int MAT_LIM = (QUAT_WIDTH < OUT_WIDTH) ? QUAT_WIDTH : OUT_WIDTH;

	// Product of two quaternion parts, and sums of up to four of them.
	localparam int PW = 2 * QUAT_WIDTH;
	localparam int MW = PW + 2;
	// Matrix entry split for the vector multiply: high signed part, low unsigned part.
	localparam int HW  = MW - QUAT_WIDTH;
	localparam int HPW = HW + VEC_WIDTH;
	localparam int LPW = QUAT_WIDTH + 1 + VEC_WIDTH;
	// Rounding width: room for the rotated sums and for the half-LSB constant.
	localparam int RW_A = MW + VEC_WIDTH + 2;
	localparam int RW   = (RW_A > 2 * FRAC_BITS + 2) ? RW_A : 2 * FRAC_BITS + 2;

	localparam logic [1:0] CMD_MUL  = 2'd0;
	localparam logic [1:0] CMD_ROT  = 2'd1;
	localparam logic [1:0] CMD_MAT  = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef logic signed [QUAT_WIDTH-1:0] quat_t;
	typedef logic signed [VEC_WIDTH-1:0]  vec_t;
	typedef logic signed [PW-1:0]         prod_t;
	typedef logic signed [MW-1:0]         ent_t;
	typedef logic signed [HPW-1:0]        hprod_t;
	typedef logic signed [LPW-1:0]        lprod_t;
	typedef logic signed [RW-1:0]         acc_t;
	typedef logic signed [OUT_WIDTH-1:0]  out_t;

	typedef struct packed {
		logic [1:0] command;
		quat_t q_w;
		quat_t q_x;
		quat_t q_y;
		quat_t q_z;
		quat_t r_w;
		quat_t r_x;
		quat_t r_y;
		quat_t r_z;
		vec_t  vec_x;
		vec_t  vec_y;
		vec_t  vec_z;
	} req_t;

	typedef struct packed {
		out_t res_0;
		out_t res_1;
		out_t res_2;
		out_t res_3;
		logic last;
	} res_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] cmd;
	} ctl_t;

	// Add half an LSB, shift right arithmetically, clamp to a signed range of lim bits.
	function automatic out_t round_sat(input acc_t v, input int unsigned s,
		input int unsigned lim);
		acc_t half;
		acc_t t;
		acc_t hi_lim;
		acc_t lo_lim;
		half = '0;
		half[s-1] = 1'b1;
		t = (v + half) >>> s;
		hi_lim = (acc_t'(1) <<< (lim - 1)) - acc_t'(1);
		lo_lim = ~hi_lim;
		if (t > hi_lim) begin
			t = hi_lim;
		end else if (t < lo_lim) begin
			t = lo_lim;
		end
		return t[OUT_WIDTH-1:0];
	endfunction

endpackage

### rtl/qru_front.sv
module qru_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  qru_pkg::req_t  req,
	output qru_pkg::ctl_t  ctl_s2,
	output qru_pkg::ent_t  ham_s2 [4],
	output qru_pkg::ent_t  mat_s2 [4][4],
	output qru_pkg::vec_t  vec_s2 [3]
);
	import qru_pkg::*;

	quat_t q [4];
	quat_t r [4];

	ctl_t  ctl_s1;
	prod_t qr_s1 [4][4];
	prod_t qq_s1 [4][4];
	vec_t  vec_s1 [3];

	assign q[0] = req.q_w;
	assign q[1] = req.q_x;
	assign q[2] = req.q_y;
	assign q[3] = req.q_z;
	assign r[0] = req.r_w;
	assign r[1] = req.r_x;
	assign r[2] = req.r_y;
	assign r[3] = req.r_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= in_valid;
			ctl_s1.cmd   <= req.command;
		end
	end

	// Stage 1: every pairwise product; only the upper triangle of q*q is used.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				qr_s1[i][j] <= prod_t'(q[i]) * prod_t'(r[j]);
				qq_s1[i][j] <= (j >= i) ? prod_t'(q[i]) * prod_t'(q[j]) : '0;
			end
		end
		vec_s1[0] <= req.vec_x;
		vec_s1[1] <= req.vec_y;
		vec_s1[2] <= req.vec_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Stage 2: Hamilton sums and the rotation matrix (a,b,c,d = w,x,y,z).
	always_ff @(posedge clk) begin
		ham_s2[0] <= ent_t'(qr_s1[0][0]) - ent_t'(qr_s1[1][1])
			- ent_t'(qr_s1[2][2]) - ent_t'(qr_s1[3][3]);
		ham_s2[1] <= ent_t'(qr_s1[0][1]) + ent_t'(qr_s1[1][0])
			+ ent_t'(qr_s1[2][3]) - ent_t'(qr_s1[3][2]);
		ham_s2[2] <= ent_t'(qr_s1[0][2]) - ent_t'(qr_s1[1][3])
			+ ent_t'(qr_s1[2][0]) + ent_t'(qr_s1[3][1]);
		ham_s2[3] <= ent_t'(qr_s1[0][3]) + ent_t'(qr_s1[1][2])
			- ent_t'(qr_s1[2][1]) + ent_t'(qr_s1[3][0]);

		mat_s2[0][0] <= ent_t'(qq_s1[0][0]) + ent_t'(qq_s1[1][1])
			- ent_t'(qq_s1[2][2]) - ent_t'(qq_s1[3][3]);
		mat_s2[1][1] <= ent_t'(qq_s1[0][0]) - ent_t'(qq_s1[1][1])
			+ ent_t'(qq_s1[2][2]) - ent_t'(qq_s1[3][3]);
		mat_s2[2][2] <= ent_t'(qq_s1[0][0]) - ent_t'(qq_s1[1][1])
			- ent_t'(qq_s1[2][2]) + ent_t'(qq_s1[3][3]);
		mat_s2[3][3] <= ent_t'(qq_s1[0][0]) + ent_t'(qq_s1[1][1])
			+ ent_t'(qq_s1[2][2]) + ent_t'(qq_s1[3][3]);
		mat_s2[1][0] <= (ent_t'(qq_s1[1][2]) + ent_t'(qq_s1[0][3])) <<< 1;
		mat_s2[2][0] <= (ent_t'(qq_s1[1][3]) - ent_t'(qq_s1[0][2])) <<< 1;
		mat_s2[0][1] <= (ent_t'(qq_s1[1][2]) - ent_t'(qq_s1[0][3])) <<< 1;
		mat_s2[2][1] <= (ent_t'(qq_s1[0][1]) + ent_t'(qq_s1[2][3])) <<< 1;
		mat_s2[0][2] <= (ent_t'(qq_s1[0][2]) + ent_t'(qq_s1[1][3])) <<< 1;
		mat_s2[1][2] <= (ent_t'(qq_s1[2][3]) - ent_t'(qq_s1[0][1])) <<< 1;
		mat_s2[3][0] <= '0;
		mat_s2[3][1] <= '0;
		mat_s2[3][2] <= '0;
		mat_s2[0][3] <= '0;
		mat_s2[1][3] <= '0;
		mat_s2[2][3] <= '0;
		vec_s2 <= vec_s1;
	end

endmodule

### rtl/qru_back.sv
module qru_back (
	input  logic           clk,
	input  logic           arst_n,
	input  qru_pkg::ctl_t  ctl_s2,
	input  qru_pkg::ent_t  ham_s2 [4],
	input  qru_pkg::ent_t  mat_s2 [4][4],
	input  qru_pkg::vec_t  vec_s2 [3],
	output qru_pkg::ctl_t  ctl_s4,
	output qru_pkg::out_t  col_s4 [4][4]
);
	import qru_pkg::*;

	ctl_t   ctl_s3;
	ent_t   ham_s3 [4];
	ent_t   mat_s3 [4][4];
	hprod_t ph_s3 [3][3];
	lprod_t pl_s3 [3][3];

	acc_t   rot [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// Stage 3: matrix times vector, each entry split so no multiplier grows past the
	// quaternion width plus two. The 3x3 rotation block sits in rows and columns 0..2.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				ph_s3[i][j] <= $signed(mat_s2[i][j][MW-1:QUAT_WIDTH]) * vec_s2[j];
				pl_s3[i][j] <= $signed({1'b0, mat_s2[i][j][QUAT_WIDTH-1:0]})
					* vec_s2[j];
			end
		end
		ham_s3 <= ham_s2;
		mat_s3 <= mat_s2;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rot[i] = '0;
			for (int j = 0; j < 3; j++) begin
				rot[i] = rot[i] + (acc_t'(ph_s3[i][j]) <<< QUAT_WIDTH)
					+ acc_t'(pl_s3[i][j]);
			end
		end
	end

	// Stage 4: round and saturate. Single-result commands use column 0 only.
	// The registers hold while no request is in flight, so a matrix can be
	// read out column by column.
	always_ff @(posedge clk) begin
		if (ctl_s3.valid) begin
			case (ctl_s3.cmd)
				CMD_MUL: begin
					for (int i = 0; i < 4; i++) begin
						col_s4[0][i] <= round_sat(acc_t'(ham_s3[i]), FRAC_BITS, OUT_WIDTH);
					end
				end
				CMD_ROT: begin
					col_s4[0][0] <= '0;
					for (int i = 0; i < 3; i++) begin
						col_s4[0][i+1] <= round_sat(rot[i], 2 * FRAC_BITS, OUT_WIDTH);
					end
				end
				CMD_MAT: begin
					for (int k = 0; k < 4; k++) begin
						for (int i = 0; i < 4; i++) begin
							col_s4[k][i] <= round_sat(acc_t'(mat_s3[i][k]), FRAC_BITS,
								MAT_LIM);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/quaternion_rotate_unit_core.sv
// A taken request passes stage registers s1 to s4, then its first result is on the
// ports for one cycle; a matrix request gives its four columns back to back.
// Throughput: one multiply or rotate request per cycle while busy is low; busy is
// set by a matrix request, not the readout, and clears before the readout ends.
// The receiver cannot stall. Reset clears all valid bits and the column counter.
module quaternion_rotate_unit_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  qru_pkg::req_t  req,
	output logic           res_valid,
	output qru_pkg::res_t  res
);
	import qru_pkg::*;

	ctl_t ctl_s2;
	ent_t ham_s2 [4];
	ent_t mat_s2 [4][4];
	vec_t vec_s2 [3];
	ctl_t ctl_s4;
	out_t col_s4 [4][4];

	logic [1:0] busy_cnt_q;
	logic [1:0] col_q;
	logic [1:0] col_sel;
	logic       accept;
	logic       s4_emit;

	assign accept = start && !busy;
	assign busy   = (busy_cnt_q != 2'd0);

	qru_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(accept),
		.req     (req),
		.ctl_s2  (ctl_s2),
		.ham_s2  (ham_s2),
		.mat_s2  (mat_s2),
		.vec_s2  (vec_s2)
	);

	qru_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s2 (ctl_s2),
		.ham_s2 (ham_s2),
		.mat_s2 (mat_s2),
		.vec_s2 (vec_s2),
		.ctl_s4 (ctl_s4),
		.col_s4 (col_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= 2'd0;
		end else if (accept && req.command == CMD_MAT) begin
			busy_cnt_q <= 2'd3;
		end else if (busy) begin
			busy_cnt_q <= busy_cnt_q - 2'd1;
		end
	end

	assign s4_emit = ctl_s4.valid && ctl_s4.cmd != CMD_NONE;

	// Column counter for the remaining three matrix columns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 2'd0;
		end else if (ctl_s4.valid && ctl_s4.cmd == CMD_MAT) begin
			col_q <= 2'd1;
		end else if (col_q != 2'd0) begin
			col_q <= col_q + 2'd1;
		end
	end

	assign col_sel   = ctl_s4.valid ? 2'd0 : col_q;
	assign res_valid = s4_emit || col_q != 2'd0;

	always_comb begin
		res.res_0 = col_s4[col_sel][0];
		res.res_1 = col_s4[col_sel][1];
		res.res_2 = col_s4[col_sel][2];
		res.res_3 = col_s4[col_sel][3];
		res.last  = ctl_s4.valid ? (ctl_s4.cmd != CMD_MAT) : (col_q == 2'd3);
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		col_q != 2'd0 |-> !ctl_s4.valid)
		else $error("new result reached the output during a matrix readout");

	a_mat_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.command == CMD_MAT |=> busy)
		else $error("matrix request did not raise busy");

	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		col_q == 2'd3 |-> res_valid && res.last)
		else $error("fourth matrix column not marked last");

endmodule
